/* design/pdb_pkg.sv */
// Shared types and constants for the position PID block with deadband.
// No dependencies; imported by every module of the block.
package pdb_pkg;

	localparam int PosW   = 16;  // Q11.4 positions and target
	localparam int GainW  = 16;  // Q8.8 gains
	localparam int BandW  = 15;  // unsigned bands and limit
	localparam int ErrW   = 17;  // error, integral, previous error
	localparam int DiffW  = 18;  // derivative difference
	localparam int DriveW = 36;  // output, 12 fraction bits
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;

	localparam logic [BandW-1:0] DeadBandRst   = BandW'(32);
	localparam logic [BandW-1:0] SepBandRst    = BandW'(160);
	localparam logic [BandW-1:0] IntLimitRst   = BandW'(160);

	typedef enum logic [CfgIdxW-1:0] {
		REG_TARGET    = 3'd0,
		REG_GAIN_P    = 3'd1,
		REG_GAIN_I    = 3'd2,
		REG_GAIN_D    = 3'd3,
		REG_DEAD_BAND = 3'd4,
		REG_SEP_BAND  = 3'd5,
		REG_INT_LIMIT = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic signed [PosW-1:0]  target;
		logic signed [GainW-1:0] gain_p;
		logic signed [GainW-1:0] gain_i;
		logic signed [GainW-1:0] gain_d;
		logic [BandW-1:0]        dead_band;
		logic [BandW-1:0]        separation_band;
		logic [BandW-1:0]        integral_limit;
	} cfg_t;

	// Error-stage result handed to the multiply stage
	typedef struct packed {
		logic                    valid;
		logic signed [ErrW-1:0]  err;
		logic signed [ErrW-1:0]  integ;
		logic signed [DiffW-1:0] diff;
	} err_stage_t;

endpackage

/* design/pdb_cfg_regs.sv */
// Configuration register file for the position PID block.
// Depends on pdb_pkg.
module pdb_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [pdb_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [pdb_pkg::CfgDataW-1:0]  cfg_data,
	output pdb_pkg::cfg_t                 cfg
);
	import pdb_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target          <= '0;
			cfg_q.gain_p          <= '0;
			cfg_q.gain_i          <= '0;
			cfg_q.gain_d          <= '0;
			cfg_q.dead_band       <= DeadBandRst;
			cfg_q.separation_band <= SepBandRst;
			cfg_q.integral_limit  <= IntLimitRst;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				REG_TARGET:    cfg_q.target          <= cfg_data;
				REG_GAIN_P:    cfg_q.gain_p          <= cfg_data;
				REG_GAIN_I:    cfg_q.gain_i          <= cfg_data;
				REG_GAIN_D:    cfg_q.gain_d          <= cfg_data;
				REG_DEAD_BAND: cfg_q.dead_band       <= cfg_data[BandW-1:0];
				REG_SEP_BAND:  cfg_q.separation_band <= cfg_data[BandW-1:0];
				REG_INT_LIMIT: cfg_q.integral_limit  <= cfg_data[BandW-1:0];
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* design/pdb_err_stage.sv */
// Input register, error/deadband/integral logic and the integral and
// previous-error state. Depends on pdb_pkg.
module pdb_err_stage (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pdb_pkg::cfg_t                     cfg,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [pdb_pkg::PosW-1:0]   measured,
	output pdb_pkg::err_stage_t               s2,
	input  logic                              s2_ready
);
	import pdb_pkg::*;

	logic                    valid_s1;
	logic signed [PosW-1:0]  measured_s1;
	logic signed [ErrW-1:0]  integ_q;
	logic signed [ErrW-1:0]  prev_q;
	logic                    valid_s2;
	logic signed [ErrW-1:0]  err_s2;
	logic signed [ErrW-1:0]  integ_s2;
	logic signed [DiffW-1:0] diff_s2;

	logic                    ready_s2;
	logic                    ready_s1;
	logic                    move_s1;
	logic signed [ErrW-1:0]  err;
	logic signed [ErrW-1:0]  db;
	logic signed [ErrW-1:0]  sb;
	logic signed [DiffW-1:0] lim;
	logic                    in_db;
	logic                    integrate;
	logic signed [ErrW-1:0]  err_z;
	logic signed [ErrW-1:0]  integ_base;
	logic signed [DiffW-1:0] sum;
	logic signed [ErrW-1:0]  integ_new;
	logic signed [DiffW-1:0] diff;

	assign ready_s2 = !valid_s2 || s2_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign move_s1  = valid_s1 && ready_s2;
	assign in_stall = !ready_s1;

	always_comb begin
		err   = ErrW'(cfg.target) - ErrW'(measured_s1);
		db    = {2'b00, cfg.dead_band};
		sb    = {2'b00, cfg.separation_band};
		lim   = {3'b000, cfg.integral_limit};
		in_db = (err >= -db) && (err <= db);
		// Deadband clears error and integral before the separation test
		err_z      = in_db ? '0 : err;
		integ_base = in_db ? '0 : integ_q;
		integrate  = (err_z > -sb) && (err_z < sb);
		sum        = DiffW'(integ_base) + DiffW'(err_z);
		if (sum > lim)
			integ_new = lim[ErrW-1:0];
		else if (sum < -lim)
			integ_new = ErrW'(-lim);
		else
			integ_new = sum[ErrW-1:0];
		if (!integrate)
			integ_new = integ_base;
		diff = DiffW'(err_z) - DiffW'(prev_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			integ_q  <= '0;
			prev_q   <= '0;
		end else begin
			if (ready_s1)
				valid_s1 <= in_valid;
			if (ready_s2)
				valid_s2 <= valid_s1;
			if (move_s1) begin
				integ_q <= integ_new;
				prev_q  <= err_z;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid)
			measured_s1 <= measured;
		if (move_s1) begin
			err_s2   <= err_z;
			integ_s2 <= integ_new;
			diff_s2  <= diff;
		end
	end

	assign s2 = {valid_s2, err_s2, integ_s2, diff_s2};

endmodule

/* design/pdb_mac.sv */
// Gain multiplies, sum and the output register of the position PID block.
// Depends on pdb_pkg.
module pdb_mac (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pdb_pkg::cfg_t                      cfg,
	input  pdb_pkg::err_stage_t                s2,
	output logic                               s2_ready,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [pdb_pkg::DriveW-1:0]  drive
);
	import pdb_pkg::*;

	logic                     valid_q;
	logic signed [DriveW-1:0] drive_q;
	logic signed [DriveW-1:0] prod_p;
	logic signed [DriveW-1:0] prod_i;
	logic signed [DriveW-1:0] prod_d;
	logic                     ready;

	assign ready = !valid_q || !out_stall;
	assign s2_ready = ready;

	always_comb begin
		prod_p = DriveW'(cfg.gain_p) * DriveW'(s2.err);
		prod_i = DriveW'(cfg.gain_i) * DriveW'(s2.integ);
		prod_d = DriveW'(cfg.gain_d) * DriveW'(s2.diff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (ready)
			valid_q <= s2.valid;
	end

	always_ff @(posedge clk) begin
		if (ready && s2.valid)
			drive_q <= prod_p + prod_i + prod_d;
	end

	assign out_valid = valid_q;
	assign drive     = drive_q;

endmodule

/* design/pid_position_deadband.sv */
// Positional PID step with deadband and integral separation. Each measured
// position (Q11.4) transfer yields one drive value with 12 fraction bits:
// error = target - measured; an error within +/-dead_band clears both the
// error and the integral; an error strictly within +/-separation_band is
// added to the integral, which is clamped to +/-integral_limit; drive is
// gain_p*err + gain_i*integral + gain_d*(err - previous error), exact.
// One item is taken every cycle while the output is not stalled; drive is
// registered through the input register, the error/integral stage and the
// multiply-and-sum output register. The integral and previous-error state
// update as an item leaves the error stage, which sets the one-per-cycle rate.
// Configuration writes are taken in any cycle and land at once; issue them
// only while the block holds no items in flight, since both stages read the
// registers directly.
module pid_position_deadband (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pdb_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [pdb_pkg::CfgDataW-1:0]      cfg_data,
	// measured position channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [pdb_pkg::PosW-1:0]   measured,
	// drive channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [pdb_pkg::DriveW-1:0] drive
);
	import pdb_pkg::*;

	cfg_t       cfg;
	err_stage_t s2;
	logic       s2_ready;

	// Register writes are always accepted
	assign cfg_ready = 1'b1;

	pdb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Error, deadband and integral; holds the controller state
	pdb_err_stage u_err (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.measured (measured),
		.s2       (s2),
		.s2_ready (s2_ready)
	);

	// Three gain products summed into the output register
	pdb_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s2        (s2),
		.s2_ready  (s2_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.drive     (drive)
	);

endmodule

/* design/pdb_checker.sv */
// Port-level checks for pid_position_deadband, attached by bind.
// Depends on pdb_pkg and the top-level port list.
module pdb_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cfg_valid,
	input logic                              cfg_ready,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [pdb_pkg::DriveW-1:0] drive
);
	import pdb_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(drive))
		else $error("stalled drive changed or dropped");

	// Input stalls only when the output is full and stalled
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || !out_stall) |-> !in_stall)
		else $error("input stalled with free output");

	// Drive shows valid after an input transfer when the output side keeps flowing
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("result missing three cycles after transfer");

	// Register writes are never held off
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write not accepted");

endmodule

bind pid_position_deadband pdb_checker u_pdb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.drive     (drive)
);
